// ===== rtl/core/fbd_pkg.sv =====
package fbd_pkg;

  // Command codes carried in the func field
  localparam logic [2:0] FUNC_CLEAR  = 3'd0;
  localparam logic [2:0] FUNC_CURSOR = 3'd1;
  localparam logic [2:0] FUNC_CHAR   = 3'd2;
  localparam logic [2:0] FUNC_BOX    = 3'd3;
  localparam logic [2:0] FUNC_FRAME  = 3'd4;
  localparam logic [2:0] FUNC_SPAN   = 3'd5;
  localparam logic [2:0] FUNC_READ   = 3'd6;

  // Configuration register indexes
  localparam logic REG_DRAW_COLOR = 1'b0;
  localparam logic REG_TEXT_SCALE = 1'b1;

  // Latched drawing command handed to the mask generator
  typedef struct packed {
    logic [2:0]  kind;
    logic [9:0]  x0;
    logic [9:0]  x1;
    logic [9:0]  y0;
    logic [9:0]  y1;
    logic [7:0]  span_bits;
    logic        color;
    logic        scale2;
    logic [47:0] glyph;
  } draw_cmd_t;

  // Pack six glyph columns, column 0 in the low byte
  function automatic logic [47:0] pack6(input logic [7:0] c0, input logic [7:0] c1,
                                        input logic [7:0] c2, input logic [7:0] c3,
                                        input logic [7:0] c4, input logic [7:0] c5);
    pack6 = {c5, c4, c3, c2, c1, c0};
  endfunction

  // Glyph ROM: lowercase promoted except 's', unknown codes give space
  function automatic logic [47:0] glyph_lookup(input logic [7:0] code);
    logic [7:0] k;
    k = code;
    if (code >= 8'h61 && code <= 8'h7a && code != 8'h73) k = code - 8'h20;
    case (k)
      8'h30: glyph_lookup = pack6(8'h3e, 8'h51, 8'h49, 8'h45, 8'h3e, 8'h00);
      8'h31: glyph_lookup = pack6(8'h00, 8'h42, 8'h7f, 8'h40, 8'h00, 8'h00);
      8'h32: glyph_lookup = pack6(8'h42, 8'h61, 8'h51, 8'h49, 8'h46, 8'h00);
      8'h33: glyph_lookup = pack6(8'h21, 8'h41, 8'h45, 8'h4b, 8'h31, 8'h00);
      8'h34: glyph_lookup = pack6(8'h18, 8'h14, 8'h12, 8'h7f, 8'h10, 8'h00);
      8'h35: glyph_lookup = pack6(8'h27, 8'h45, 8'h45, 8'h45, 8'h39, 8'h00);
      8'h36: glyph_lookup = pack6(8'h3c, 8'h4a, 8'h49, 8'h49, 8'h30, 8'h00);
      8'h37: glyph_lookup = pack6(8'h01, 8'h71, 8'h09, 8'h05, 8'h03, 8'h00);
      8'h38: glyph_lookup = pack6(8'h36, 8'h49, 8'h49, 8'h49, 8'h36, 8'h00);
      8'h39: glyph_lookup = pack6(8'h06, 8'h49, 8'h49, 8'h29, 8'h1e, 8'h00);
      8'h2e: glyph_lookup = pack6(8'h00, 8'h60, 8'h60, 8'h00, 8'h00, 8'h00);
      8'h3a: glyph_lookup = pack6(8'h00, 8'h36, 8'h36, 8'h00, 8'h00, 8'h00);
      8'h25: glyph_lookup = pack6(8'h62, 8'h64, 8'h08, 8'h13, 8'h23, 8'h00);
      8'h41: glyph_lookup = pack6(8'h7e, 8'h11, 8'h11, 8'h11, 8'h7e, 8'h00);
      8'h42: glyph_lookup = pack6(8'h7f, 8'h49, 8'h49, 8'h49, 8'h36, 8'h00);
      8'h43: glyph_lookup = pack6(8'h3e, 8'h41, 8'h41, 8'h41, 8'h22, 8'h00);
      8'h44: glyph_lookup = pack6(8'h7f, 8'h41, 8'h41, 8'h22, 8'h1c, 8'h00);
      8'h45: glyph_lookup = pack6(8'h7f, 8'h49, 8'h49, 8'h49, 8'h41, 8'h00);
      8'h46: glyph_lookup = pack6(8'h7f, 8'h09, 8'h09, 8'h09, 8'h01, 8'h00);
      8'h47: glyph_lookup = pack6(8'h3e, 8'h41, 8'h49, 8'h49, 8'h7a, 8'h00);
      8'h48: glyph_lookup = pack6(8'h7f, 8'h08, 8'h08, 8'h08, 8'h7f, 8'h00);
      8'h49: glyph_lookup = pack6(8'h00, 8'h41, 8'h7f, 8'h41, 8'h00, 8'h00);
      8'h4a: glyph_lookup = pack6(8'h20, 8'h40, 8'h41, 8'h3f, 8'h01, 8'h00);
      8'h4b: glyph_lookup = pack6(8'h7f, 8'h08, 8'h14, 8'h22, 8'h41, 8'h00);
      8'h4c: glyph_lookup = pack6(8'h7f, 8'h40, 8'h40, 8'h40, 8'h40, 8'h00);
      8'h4d: glyph_lookup = pack6(8'h7f, 8'h02, 8'h04, 8'h02, 8'h7f, 8'h00);
      8'h4e: glyph_lookup = pack6(8'h7f, 8'h04, 8'h08, 8'h10, 8'h7f, 8'h00);
      8'h4f: glyph_lookup = pack6(8'h3e, 8'h41, 8'h41, 8'h41, 8'h3e, 8'h00);
      8'h50: glyph_lookup = pack6(8'h7f, 8'h09, 8'h09, 8'h09, 8'h06, 8'h00);
      8'h51: glyph_lookup = pack6(8'h3e, 8'h41, 8'h51, 8'h21, 8'h5e, 8'h00);
      8'h52: glyph_lookup = pack6(8'h7f, 8'h09, 8'h19, 8'h29, 8'h46, 8'h00);
      8'h53: glyph_lookup = pack6(8'h46, 8'h49, 8'h49, 8'h49, 8'h31, 8'h00);
      8'h54: glyph_lookup = pack6(8'h01, 8'h01, 8'h7f, 8'h01, 8'h01, 8'h00);
      8'h55: glyph_lookup = pack6(8'h3f, 8'h40, 8'h40, 8'h40, 8'h3f, 8'h00);
      8'h56: glyph_lookup = pack6(8'h1f, 8'h20, 8'h40, 8'h20, 8'h1f, 8'h00);
      8'h57: glyph_lookup = pack6(8'h7f, 8'h20, 8'h18, 8'h20, 8'h7f, 8'h00);
      8'h58: glyph_lookup = pack6(8'h63, 8'h14, 8'h08, 8'h14, 8'h63, 8'h00);
      8'h59: glyph_lookup = pack6(8'h07, 8'h08, 8'h70, 8'h08, 8'h07, 8'h00);
      8'h5a: glyph_lookup = pack6(8'h61, 8'h51, 8'h49, 8'h45, 8'h43, 8'h00);
      8'h73: glyph_lookup = pack6(8'h26, 8'h49, 8'h49, 8'h49, 8'h32, 8'h00);
      default: glyph_lookup = '0;
    endcase
  endfunction

endpackage

// ===== rtl/core/fbd_cmd_if.sv =====
interface fbd_cmd_if;
  logic       valid;
  logic       ready;
  logic [2:0] func;
  logic [7:0] x_pos;
  logic [7:0] y_pos;
  logic [7:0] width_px;
  logic [7:0] height_px;
  logic [7:0] char_code;
  logic       wrap_enable;
  logic [7:0] span_bits;
  logic [3:0] span_count;

  modport source (output valid, output func, output x_pos, output y_pos, output width_px,
                  output height_px, output char_code, output wrap_enable, output span_bits,
                  output span_count, input ready);
  modport sink (input valid, input func, input x_pos, input y_pos, input width_px,
                input height_px, input char_code, input wrap_enable, input span_bits,
                input span_count, output ready);
endinterface

// ===== rtl/core/fbd_res_if.sv =====
interface fbd_res_if;
  logic       valid;
  logic       ready;
  logic [7:0] read_data;
  logic [7:0] dropped;

  modport source (output valid, output read_data, output dropped, input ready);
  modport sink (input valid, input read_data, input dropped, output ready);
endinterface

// ===== rtl/core/mono_framebuffer_draw_engine.sv =====
// Channel | Dir | Beat contents
// cmd     | in  | func, x_pos, y_pos, width_px, height_px, char_code, wrap_enable,
//         |     | span_bits, span_count
// res     | out | read_data, dropped
// apb     | in  | draw_color at 0x0, text_scale at 0x4
//
// Each touched framebuffer byte is read, then written back, on the single RAM port.
// After reset a clearing pass over the whole screen runs before cmd is ready.
// A finished result waits in the output register; the next command is taken meanwhile.

module mono_framebuffer_draw_engine
  import fbd_pkg::*;
#(
  parameter int SCREEN_WIDTH  = 128,
  parameter int SCREEN_HEIGHT = 64
) (
  input  logic        clk,
  input  logic        rst,
  fbd_cmd_if.sink     cmd,
  fbd_res_if.source   res,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam int PAGES = (SCREEN_HEIGHT + 7) / 8;
  localparam int CW    = $clog2(SCREEN_WIDTH);
  localparam int PW    = (PAGES > 1) ? $clog2(PAGES) : 1;
  localparam int DEPTH = SCREEN_WIDTH * PAGES;
  localparam int AW    = $clog2(DEPTH);

  typedef enum logic [1:0] {ST_IDLE, ST_RD, ST_WR, ST_FIN} state_t;

  state_t        state;
  logic          draw_color;
  logic          scale2;
  logic [7:0]    cursor_x;
  logic [7:0]    cursor_y;
  draw_cmd_t     cur;
  logic [CW-1:0] col;
  logic [PW-1:0] page;
  logic [CW-1:0] col_first;
  logic [CW-1:0] col_last;
  logic [PW-1:0] page_last;
  logic          quiet;
  logic [7:0]    res_rd;
  logic          res_drop;
  logic          out_valid;
  logic [7:0]    out_rd;
  logic          out_drop;

  draw_cmd_t     d;
  logic          d_walk;
  logic          d_read;
  logic          d_drop;
  logic [7:0]    cx_next;
  logic [7:0]    cy_next;
  logic [3:0]    cnt;
  logic [7:0]    sc6;
  logic [7:0]    sc8;
  logic          wrap_need;
  logic [7:0]    wrap_y;
  logic [7:0]    gx;
  logic [7:0]    gy;

  logic [AW-1:0] ram_addr;
  logic          ram_we;
  logic [7:0]    ram_rdata;
  logic [7:0]    mask;
  logic          cfg_we;

  assign pready = 1'b1;
  assign cfg_we = psel && penable && pwrite;
  assign prdata = (paddr[2] == REG_TEXT_SCALE) ? {30'd0, scale2, ~scale2}
                                               : {31'd0, draw_color};

  assign cmd.ready     = (state == ST_IDLE);
  assign res.valid     = out_valid;
  assign res.read_data = out_rd;
  assign res.dropped   = {7'd0, out_drop};

  // Decode the incoming command into a box of columns and rows, the next cursor and the read and drop flags
  always_comb begin
    sc6       = scale2 ? 8'd12 : 8'd6;
    sc8       = scale2 ? 8'd16 : 8'd8;
    wrap_need = cmd.wrap_enable && ({1'b0, cursor_x} + {1'b0, sc6} > 9'(SCREEN_WIDTH));
    wrap_y    = cursor_y + sc8;
    gx        = wrap_need ? 8'd0 : cursor_x;
    gy        = wrap_need ? wrap_y : cursor_y;
    cnt       = (cmd.span_count > 4'd8) ? 4'd8 : cmd.span_count;
    d.kind      = cmd.func;
    d.x0        = {2'b0, cmd.x_pos};
    d.x1        = {2'b0, cmd.x_pos} + {2'b0, cmd.width_px} - 10'd1;
    d.y0        = {2'b0, cmd.y_pos};
    d.y1        = {2'b0, cmd.y_pos} + {2'b0, cmd.height_px} - 10'd1;
    d.span_bits = cmd.span_bits;
    d.color     = draw_color;
    d.scale2    = scale2;
    d.glyph     = glyph_lookup(cmd.char_code);
    d_walk  = 1'b0;
    d_read  = 1'b0;
    d_drop  = 1'b0;
    cx_next = cursor_x;
    cy_next = cursor_y;
    case (cmd.func)
      FUNC_CLEAR: begin
        d.x0    = '0;
        d.x1    = 10'(SCREEN_WIDTH - 1);
        d.y0    = '0;
        d.y1    = 10'(SCREEN_HEIGHT - 1);
        d.color = 1'b0;
        d_walk  = 1'b1;
      end
      FUNC_CURSOR: begin
        cx_next = {cmd.x_pos[4:0], 3'b000};
        cy_next = {cmd.y_pos[4:0], 3'b000};
      end
      FUNC_CHAR: begin
        d_drop  = wrap_need && (wrap_y >= 8'(SCREEN_HEIGHT));
        d.x0    = {2'b0, gx};
        d.x1    = {2'b0, gx} + {2'b0, sc6} - 10'd1;
        d.y0    = {2'b0, gy};
        d.y1    = {2'b0, gy} + {2'b0, sc8} - 10'd1;
        d_walk  = !d_drop;
        cx_next = d_drop ? 8'd0 : gx + sc6;
        cy_next = gy;
      end
      FUNC_BOX, FUNC_FRAME: d_walk = (cmd.width_px != 8'd0) && (cmd.height_px != 8'd0);
      FUNC_SPAN: begin
        d.x1   = {2'b0, cmd.x_pos} + {6'd0, cnt} - 10'd1;
        d.y1   = d.y0;
        d_walk = (cnt != 4'd0);
      end
      FUNC_READ: d_read = (cmd.x_pos < 8'(SCREEN_WIDTH)) && (cmd.y_pos < 8'(PAGES));
      default: ;
    endcase
    if (d.x0 >= 10'(SCREEN_WIDTH) || d.y0 >= 10'(SCREEN_HEIGHT)) d_walk = 1'b0;
  end

  // Walk pages outer, columns inner; each byte is read, then written back
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_RD;
      quiet       <= 1'b1;
      draw_color  <= 1'b1;
      scale2      <= 1'b0;
      cursor_x    <= '0;
      cursor_y    <= '0;
      out_valid   <= 1'b0;
      col         <= '0;
      page        <= '0;
      col_first   <= '0;
      col_last    <= CW'(SCREEN_WIDTH - 1);
      page_last   <= PW'(PAGES - 1);
      cur.kind    <= FUNC_CLEAR;
      cur.x0      <= '0;
      cur.x1      <= 10'(SCREEN_WIDTH - 1);
      cur.y0      <= '0;
      cur.y1      <= 10'(SCREEN_HEIGHT - 1);
      cur.color   <= 1'b0;
      cur.scale2  <= 1'b0;
      cur.span_bits <= '0;
      cur.glyph   <= '0;
    end else begin
      if (cfg_we) begin
        if (paddr[2] == REG_DRAW_COLOR) draw_color <= pwdata[0];
        else scale2 <= (pwdata[1:0] == 2'd2);
      end
      // Drop the taken beat unless a new result replaces it this cycle
      if (res.valid && res.ready && !(state == ST_FIN && !quiet)) out_valid <= 1'b0;
      unique case (state)
        ST_IDLE: begin
          if (cmd.valid) begin
            cur      <= d;
            quiet    <= 1'b0;
            res_rd   <= '0;
            res_drop <= d_drop;
            cursor_x <= cx_next;
            cursor_y <= cy_next;
            if (d_read) begin
              col   <= cmd.x_pos[CW-1:0];
              page  <= PW'(cmd.y_pos);
              state <= ST_RD;
            end else if (d_walk) begin
              col       <= d.x0[CW-1:0];
              col_first <= d.x0[CW-1:0];
              col_last  <= (d.x1 >= 10'(SCREEN_WIDTH)) ? CW'(SCREEN_WIDTH - 1)
                                                       : d.x1[CW-1:0];
              page      <= PW'(d.y0 >> 3);
              page_last <= ((d.y1 >> 3) >= 10'(PAGES)) ? PW'(PAGES - 1)
                                                       : PW'(d.y1 >> 3);
              state     <= ST_RD;
            end else begin
              state <= ST_FIN;
            end
          end
        end
        ST_RD: state <= ST_WR;
        ST_WR: begin
          if (cur.kind == FUNC_READ) begin
            res_rd <= ram_rdata;
            state  <= ST_FIN;
          end else if (col == col_last) begin
            col <= col_first;
            if (page == page_last) state <= ST_FIN;
            else begin
              page  <= page + 1'b1;
              state <= ST_RD;
            end
          end else begin
            col   <= col + 1'b1;
            state <= ST_RD;
          end
        end
        ST_FIN: begin
          if (quiet) begin
            state <= ST_IDLE;
          end else if (!out_valid || res.ready) begin
            out_valid <= 1'b1;
            out_rd    <= res_rd;
            out_drop  <= res_drop;
            state     <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  assign ram_addr = AW'(page * SCREEN_WIDTH + col);
  assign ram_we   = (state == ST_WR) && (cur.kind != FUNC_READ);

  fbd_mask_gen #(
    .SCREEN_HEIGHT (SCREEN_HEIGHT),
    .CW            (CW),
    .PW            (PW)
  ) u_mask (
    .cmd  (cur),
    .col  (col),
    .page (page),
    .mask (mask)
  );

  fbd_frame_ram #(
    .DEPTH (DEPTH),
    .AW    (AW)
  ) u_ram (
    .clk   (clk),
    .addr  (ram_addr),
    .we    (ram_we),
    .wdata (cur.color ? (ram_rdata | mask) : (ram_rdata & ~mask)),
    .rdata (ram_rdata)
  );

endmodule

// ===== rtl/core/fbd_frame_ram.sv =====
module fbd_frame_ram #(
  parameter int DEPTH = 1024,
  parameter int AW    = 10
) (
  input  logic          clk,
  input  logic [AW-1:0] addr,
  input  logic          we,
  input  logic [7:0]    wdata,
  output logic [7:0]    rdata
);

  logic [7:0] mem [DEPTH];

  // Single port, registered read
  always_ff @(posedge clk) begin
    if (we) mem[addr] <= wdata;
    rdata <= mem[addr];
  end

endmodule

// ===== rtl/core/fbd_mask_gen.sv =====
module fbd_mask_gen
  import fbd_pkg::*;
#(
  parameter int SCREEN_HEIGHT = 64,
  parameter int CW            = 7,
  parameter int PW            = 3
) (
  input  draw_cmd_t     cmd,
  input  logic [CW-1:0] col,
  input  logic [PW-1:0] page,
  output logic [7:0]    mask
);

  logic [9:0] col_w;
  logic [9:0] coff;
  logic [2:0] gcol;
  logic       span_on;

  assign col_w   = 10'(col);
  assign coff    = col_w - cmd.x0;
  assign gcol    = cmd.scale2 ? coff[3:1] : coff[2:0];
  // Set bits draw in the color; clear color also wipes the unset bits
  assign span_on = !cmd.color | cmd.span_bits[~coff[2:0]];

  // Decide each row bit of the byte independently
  always_comb begin
    for (int b = 0; b < 8; b++) begin
      logic [9:0] yy;
      logic [9:0] roff;
      logic [2:0] grow;
      logic       inrow;
      yy    = 10'({page, 3'(b)});
      roff  = yy - cmd.y0;
      grow  = cmd.scale2 ? roff[3:1] : roff[2:0];
      inrow = (yy >= cmd.y0) && (yy <= cmd.y1) && (yy < 10'(SCREEN_HEIGHT));
      case (cmd.kind)
        FUNC_FRAME: mask[b] = inrow && (col_w == cmd.x0 || col_w == cmd.x1 ||
                                        yy == cmd.y0 || yy == cmd.y1);
        FUNC_SPAN:  mask[b] = inrow && span_on;
        FUNC_CHAR:  mask[b] = inrow && cmd.glyph[{gcol, grow}];
        default:    mask[b] = inrow;
      endcase
    end
  end

endmodule

// ===== rtl/core/fbd_checker.sv =====
module fbd_checker (
  input logic       clk,
  input logic       rst,
  input logic       cmd_valid,
  input logic       cmd_ready,
  input logic       res_valid,
  input logic       res_ready,
  input logic [7:0] res_read_data,
  input logic [7:0] res_dropped
);

  // Hold the command side off as the clearing pass starts after reset
  a_init_busy: assert property (@(posedge clk) rst |=> !cmd_ready)
    else $error("cmd ready right after reset");

  // A taken command makes the engine drop cmd ready
  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    cmd_valid && cmd_ready |=> !cmd_ready)
    else $error("cmd taken on back-to-back cycles");

  // Hold a stalled result beat
  a_res_hold: assert property (@(posedge clk) disable iff (rst)
    res_valid && !res_ready |=> res_valid && $stable(res_read_data) && $stable(res_dropped))
    else $error("stalled result changed");

  // Drop flag is a single bit and never comes with read data
  a_drop_flag: assert property (@(posedge clk) disable iff (rst)
    res_valid |-> (res_dropped == 8'd0) || (res_dropped == 8'd1 && res_read_data == 8'd0))
    else $error("bad dropped value");

endmodule

bind mono_framebuffer_draw_engine fbd_checker u_fbd_checker (
  .clk           (clk),
  .rst           (rst),
  .cmd_valid     (cmd.valid),
  .cmd_ready     (cmd.ready),
  .res_valid     (res.valid),
  .res_ready     (res.ready),
  .res_read_data (res.read_data),
  .res_dropped   (res.dropped)
);
